// ----- rtl/core/cirm_pkg.sv -----
// Package for the CPU idle rate monitor: field widths, reset values,
// register indexes, request codes and the controller state type.
// No dependencies; every other file of the block uses it.
package cirm_pkg;

  localparam int CPU_COUNT_DEF  = 8;
  localparam int CLUSTER_COUNT  = 3;
  localparam int CPU_W          = 3;
  localparam int CTR_W          = 64;
  localparam int CAP_W          = 11;
  localparam int PCT_W          = 7;
  localparam int CL_W           = 2;
  localparam int REQ_W          = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 11;

  localparam logic [PCT_W-1:0] FULL_PERCENT  = 7'd100;
  localparam logic [PCT_W-1:0] DEFAULT_ALERT = 7'd12;
  localparam logic [CPU_W-1:0] LITTLE_LAST_RST = 3'd3;
  localparam logic [CPU_W-1:0] MID_LAST_RST    = 3'd6;
  localparam logic [CPU_W-1:0] BIG_LAST_RST    = 3'd7;
  localparam logic [CAP_W-1:0] CAP_LIMIT_RST   = 11'd1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_LAST_CPU  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LAST_CPU     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_LAST_CPU     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_CAP_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MID_CAP_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_CAP_LIMIT    = 3'd6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [CL_W-1:0] CL_LITTLE = 2'd0;
  localparam logic [CL_W-1:0] CL_MID    = 2'd1;
  localparam logic [CL_W-1:0] CL_BIG    = 2'd2;

  localparam logic signed [REQ_W-1:0] REQ_NONE  = 2'sb00;
  localparam logic signed [REQ_W-1:0] REQ_RAISE = 2'sb01;
  localparam logic signed [REQ_W-1:0] REQ_LOWER = 2'sb11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA_IDLE,
    S_DELTA_WALL,
    S_CHECK,
    S_DOUBLE,
    S_ADD,
    S_FINISH
  } state_t;

endpackage

// ----- rtl/core/cirm_if.sv -----
// Handshake channels of the CPU idle rate monitor: sample input, result
// output and configuration write. Depends on cirm_pkg for field widths.

interface cirm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [cirm_pkg::CPU_W-1:0]     cpu;
  logic [cirm_pkg::CTR_W-1:0]     idle_total;
  logic [cirm_pkg::CTR_W-1:0]     wall_total;
  logic [cirm_pkg::CAP_W-1:0]     current_cap;

  modport source (output valid, opcode, cpu, idle_total, wall_total, current_cap,
                  input ready);
  modport sink   (input valid, opcode, cpu, idle_total, wall_total, current_cap,
                  output ready);
endinterface

interface cirm_out_if;
  logic                              valid;
  logic                              ready;
  logic [cirm_pkg::PCT_W-1:0]        idle_percent;
  logic [cirm_pkg::CL_W-1:0]         cluster;
  logic                              measured;
  logic signed [cirm_pkg::REQ_W-1:0] cluster_request;
  logic                              background_pending;

  modport source (output valid, idle_percent, cluster, measured, cluster_request,
                  background_pending, input ready);
  modport sink   (input valid, idle_percent, cluster, measured, cluster_request,
                  background_pending, output ready);
endinterface

interface cirm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cirm_pkg::CFG_IDX_W-1:0]     index;
  logic [cirm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cpu_idle_rate_monitor.sv -----
// Top level of the CPU idle rate monitor: counter store, delta and
// percentage datapath, cluster request flags. Depends on cirm_pkg, cirm_if.
//
// Usage. The sample channel carries one beat per item: a CPU sample
// (opcode 0) with the cumulative idle and wall counters, or a clear of the
// background pending flag (opcode 1). Every item gives exactly one beat on
// the result channel. The configuration channel is ready out of reset and is
// to be written only while the block is idle.
// A clear or a CPU at or above CPU_COUNT goes straight to the finish step;
// an unmeasured or saturated sample first takes the idle and wall deltas
// and the check; a sample that needs the ratio then also runs the ratio
// steps. The ratio is worked out bit by bit over the constant 100 (a
// doubling step for each bit and, where the bit is set, an addition step)
// through one 65-bit adder and comparator. One item is in flight at a time;
// sample.ready returns the cycle after the result is loaded, so a new item
// may be taken while that result still waits in the output register.
// When the receiver stalls, the result is held and a finished item waits in
// its last step until the register frees. Reset clears the stored counters
// (by valid bits), the flags and requests, and loads the register defaults.
module cpu_idle_rate_monitor #(
  parameter int CPU_COUNT = cirm_pkg::CPU_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  cirm_in_if.sink    sample,
  cirm_out_if.source result,
  cirm_cfg_if.sink   cfg
);

  localparam int DEPTH = (CPU_COUNT < (1 << cirm_pkg::CPU_W)) ? CPU_COUNT
                                                               : (1 << cirm_pkg::CPU_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTR_W = cirm_pkg::CTR_W;
  localparam int PCT_W = cirm_pkg::PCT_W;
  localparam int SR_W  = PCT_W - 1;
  localparam int CNT_W = $clog2(SR_W + 1);

  // Configuration registers
  logic [PCT_W-1:0]           alert_threshold;
  logic [cirm_pkg::CPU_W-1:0] little_last_cpu, mid_last_cpu, big_last_cpu;
  logic [cirm_pkg::CAP_W-1:0] little_cap_limit, mid_cap_limit, big_cap_limit;

  // Stored counters
  logic [CTR_W-1:0] last_idle [DEPTH];
  logic [CTR_W-1:0] last_wall [DEPTH];
  logic [DEPTH-1:0] entry_valid;

  logic                              pending_flag;
  logic signed [cirm_pkg::REQ_W-1:0] cluster_requests [cirm_pkg::CLUSTER_COUNT];

  // Item registers
  cirm_pkg::state_t           state, state_next;
  logic                       op;
  logic [cirm_pkg::CPU_W-1:0] cpu;
  logic [CTR_W-1:0]           idle_val;
  logic [CTR_W-1:0]           wall_val;
  logic [cirm_pkg::CAP_W-1:0] cap;
  logic [cirm_pkg::CL_W-1:0]  cl;
  logic                       meas;
  logic [PCT_W-1:0]           quo;
  logic [CTR_W-1:0]           rem;
  logic [SR_W-1:0]            digits;
  logic [CNT_W-1:0]           steps;

  // Output register
  logic                              out_valid;
  logic [PCT_W-1:0]                  out_pct;
  logic [cirm_pkg::CL_W-1:0]         out_cl;
  logic                              out_meas;
  logic signed [cirm_pkg::REQ_W-1:0] out_req;
  logic                              out_pending;

  logic                       accept;
  logic                       in_range;
  logic [cirm_pkg::CL_W-1:0]  cl_in;
  logic [IDX_W-1:0]           idx;
  logic [CTR_W-1:0]           prev_idle, prev_wall;
  logic [CTR_W:0]             sum, diff;
  logic                       ge;
  logic                       out_free;
  logic [cirm_pkg::CAP_W-1:0] cap_limit;
  logic signed [cirm_pkg::REQ_W-1:0] req_cur, req_new;
  logic                       pending_new;
  logic                       finish_load;

  assign sample.ready = (state == cirm_pkg::S_IDLE) && !rst;
  assign cfg.ready    = !rst;
  assign accept       = sample.valid && sample.ready;
  assign out_free     = !out_valid || result.ready;

  assign result.valid              = out_valid;
  assign result.idle_percent       = out_pct;
  assign result.cluster            = out_cl;
  assign result.measured           = out_meas;
  assign result.cluster_request    = out_req;
  assign result.background_pending = out_pending;

  // Cluster of the incoming CPU; a CPU above every bound falls to cluster zero.
  always_comb begin
    if (sample.cpu <= little_last_cpu) begin
      cl_in = cirm_pkg::CL_LITTLE;
    end else if (sample.cpu <= mid_last_cpu) begin
      cl_in = cirm_pkg::CL_MID;
    end else if (sample.cpu <= big_last_cpu) begin
      cl_in = cirm_pkg::CL_BIG;
    end else begin
      cl_in = cirm_pkg::CL_LITTLE;
    end
  end

  assign in_range  = (32'(sample.cpu) < CPU_COUNT);
  assign idx       = cpu[IDX_W-1:0];
  assign prev_idle = entry_valid[idx] ? last_idle[idx] : '0;
  assign prev_wall = entry_valid[idx] ? last_wall[idx] : '0;

  // One step of the ratio: the partial product 100 * idle is kept as
  // quo * wall + rem with rem below wall, doubled or increased by idle.
  assign sum  = {1'b0, rem} + {1'b0, (state == cirm_pkg::S_ADD) ? idle_val : rem};
  assign diff = sum - {1'b0, wall_val};
  assign ge   = !diff[CTR_W];

  always_comb begin
    case (cl)
      cirm_pkg::CL_MID: cap_limit = mid_cap_limit;
      cirm_pkg::CL_BIG: cap_limit = big_cap_limit;
      default:          cap_limit = little_cap_limit;
    endcase
  end

  always_comb begin
    case (cl)
      cirm_pkg::CL_MID: req_cur = cluster_requests[1];
      cirm_pkg::CL_BIG: req_cur = cluster_requests[2];
      default:          req_cur = cluster_requests[0];
    endcase
  end

  always_comb begin
    req_new     = req_cur;
    pending_new = pending_flag;
    if (op == cirm_pkg::OP_CLEAR) begin
      pending_new = 1'b0;
    end else if (meas) begin
      if (quo < alert_threshold) begin
        pending_new = 1'b1;
        req_new     = cirm_pkg::REQ_RAISE;
      end else if (cap > cap_limit) begin
        pending_new = 1'b1;
        req_new     = cirm_pkg::REQ_LOWER;
      end
    end
  end

  // Controller
  always_comb begin
    state_next  = state;
    finish_load = 1'b0;
    case (state)
      cirm_pkg::S_IDLE: begin
        if (accept) begin
          if (sample.opcode == cirm_pkg::OP_CLEAR || !in_range) begin
            state_next = cirm_pkg::S_FINISH;
          end else begin
            state_next = cirm_pkg::S_DELTA_IDLE;
          end
        end
      end
      cirm_pkg::S_DELTA_IDLE: state_next = cirm_pkg::S_DELTA_WALL;
      cirm_pkg::S_DELTA_WALL: state_next = cirm_pkg::S_CHECK;
      cirm_pkg::S_CHECK: begin
        if (wall_val == '0 || idle_val >= wall_val) begin
          state_next = cirm_pkg::S_FINISH;
        end else begin
          state_next = cirm_pkg::S_DOUBLE;
        end
      end
      cirm_pkg::S_DOUBLE: begin
        if (digits[SR_W-1]) begin
          state_next = cirm_pkg::S_ADD;
        end else if (steps == CNT_W'(1)) begin
          state_next = cirm_pkg::S_FINISH;
        end
      end
      cirm_pkg::S_ADD: begin
        if (steps == '0) begin
          state_next = cirm_pkg::S_FINISH;
        end else begin
          state_next = cirm_pkg::S_DOUBLE;
        end
      end
      cirm_pkg::S_FINISH: begin
        if (out_free) begin
          finish_load = 1'b1;
          state_next  = cirm_pkg::S_IDLE;
        end
      end
      default: state_next = cirm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cirm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_threshold  <= cirm_pkg::DEFAULT_ALERT;
      little_last_cpu  <= cirm_pkg::LITTLE_LAST_RST;
      mid_last_cpu     <= cirm_pkg::MID_LAST_RST;
      big_last_cpu     <= cirm_pkg::BIG_LAST_RST;
      little_cap_limit <= cirm_pkg::CAP_LIMIT_RST;
      mid_cap_limit    <= cirm_pkg::CAP_LIMIT_RST;
      big_cap_limit    <= cirm_pkg::CAP_LIMIT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        cirm_pkg::REG_ALERT_THRESHOLD:  alert_threshold  <= cfg.data[PCT_W-1:0];
        cirm_pkg::REG_LITTLE_LAST_CPU:  little_last_cpu  <= cfg.data[cirm_pkg::CPU_W-1:0];
        cirm_pkg::REG_MID_LAST_CPU:     mid_last_cpu     <= cfg.data[cirm_pkg::CPU_W-1:0];
        cirm_pkg::REG_BIG_LAST_CPU:     big_last_cpu     <= cfg.data[cirm_pkg::CPU_W-1:0];
        cirm_pkg::REG_LITTLE_CAP_LIMIT: little_cap_limit <= cfg.data[cirm_pkg::CAP_W-1:0];
        cirm_pkg::REG_MID_CAP_LIMIT:    mid_cap_limit    <= cfg.data[cirm_pkg::CAP_W-1:0];
        cirm_pkg::REG_BIG_CAP_LIMIT:    big_cap_limit    <= cfg.data[cirm_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Counter store: the new counters go in as the deltas are taken.
  always_ff @(posedge clk) begin
    if (state == cirm_pkg::S_DELTA_IDLE) begin
      last_idle[idx] <= idle_val;
    end
    if (state == cirm_pkg::S_DELTA_WALL) begin
      last_wall[idx] <= wall_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (state == cirm_pkg::S_DELTA_WALL) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      cirm_pkg::S_IDLE: begin
        if (accept) begin
          op       <= sample.opcode;
          cpu      <= sample.cpu;
          idle_val <= sample.idle_total;
          wall_val <= sample.wall_total;
          cap      <= sample.current_cap;
          cl       <= cl_in;
          meas     <= 1'b0;
          quo      <= '0;
        end
      end
      cirm_pkg::S_DELTA_IDLE: idle_val <= idle_val - prev_idle;
      cirm_pkg::S_DELTA_WALL: wall_val <= wall_val - prev_wall;
      cirm_pkg::S_CHECK: begin
        meas   <= (wall_val != '0);
        rem    <= idle_val;
        digits <= cirm_pkg::FULL_PERCENT[SR_W-1:0];
        steps  <= CNT_W'(SR_W);
        if (wall_val == '0) begin
          quo <= '0;
        end else if (idle_val >= wall_val) begin
          quo <= cirm_pkg::FULL_PERCENT;
        end else begin
          // the leading bit of 100 is one: the partial product starts as idle
          quo <= '0;
        end
      end
      cirm_pkg::S_DOUBLE: begin
        rem    <= ge ? diff[CTR_W-1:0] : sum[CTR_W-1:0];
        quo    <= {quo[PCT_W-2:0], ge};
        digits <= {digits[SR_W-2:0], 1'b0};
        steps  <= steps - CNT_W'(1);
      end
      cirm_pkg::S_ADD: begin
        rem <= ge ? diff[CTR_W-1:0] : sum[CTR_W-1:0];
        quo <= quo + PCT_W'(ge);
      end
      default: ;
    endcase
  end

  // Flags and requests
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flag <= 1'b0;
      for (int i = 0; i < cirm_pkg::CLUSTER_COUNT; i++) begin
        cluster_requests[i] <= cirm_pkg::REQ_NONE;
      end
    end else if (finish_load) begin
      pending_flag <= pending_new;
      if (op == cirm_pkg::OP_SAMPLE) begin
        case (cl)
          cirm_pkg::CL_MID: cluster_requests[1] <= req_new;
          cirm_pkg::CL_BIG: cluster_requests[2] <= req_new;
          default:          cluster_requests[0] <= req_new;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      out_pending <= pending_new;
      if (op == cirm_pkg::OP_CLEAR) begin
        out_pct  <= '0;
        out_cl   <= cirm_pkg::CL_LITTLE;
        out_meas <= 1'b0;
        out_req  <= cirm_pkg::REQ_NONE;
      end else begin
        out_pct  <= quo;
        out_cl   <= cl;
        out_meas <= meas;
        out_req  <= req_new;
      end
    end
  end

endmodule

// ----- tb/cpu_idle_rate_monitor_tb.sv -----
// Self-checking testbench for cpu_idle_rate_monitor: directed and random CPU samples
// and clears, checked beat by beat against a predictor of the idle rate and flags.
// Depends on cirm_pkg, the cirm interfaces and the cpu_idle_rate_monitor RTL.
module cpu_idle_rate_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cirm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int MAX_REPORTS    = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic             opcode;
    logic [CPU_W-1:0] cpu;
    logic [CTR_W-1:0] idle_total;
    logic [CTR_W-1:0] wall_total;
    logic [CAP_W-1:0] current_cap;
  } cpu_sample_t;

  typedef struct packed {
    logic [PCT_W-1:0]        idle_percent;
    logic [CL_W-1:0]         cluster;
    logic                    measured;
    logic signed [REQ_W-1:0] cluster_request;
    logic                    background_pending;
  } rate_report_t;

  class rate_scoreboard;
    logic [PCT_W-1:0]        alert;
    logic [CPU_W-1:0]        last_cpu [CLUSTER_COUNT];
    logic [CAP_W-1:0]        cap_limit [CLUSTER_COUNT];
    logic [CTR_W-1:0]        prev_idle [CPU_COUNT_DEF];
    logic [CTR_W-1:0]        prev_wall [CPU_COUNT_DEF];
    logic                    bg_pending;
    logic signed [REQ_W-1:0] request [CLUSTER_COUNT];
    rate_report_t            awaited[$];
    int                      errors;
    int                      checked;

    function new();
      alert = DEFAULT_ALERT;
      last_cpu[CL_LITTLE] = LITTLE_LAST_RST;
      last_cpu[CL_MID] = MID_LAST_RST;
      last_cpu[CL_BIG] = BIG_LAST_RST;
      foreach (cap_limit[i]) cap_limit[i] = CAP_LIMIT_RST;
      foreach (prev_idle[i]) begin
        prev_idle[i] = '0;
        prev_wall[i] = '0;
      end
      foreach (request[i]) request[i] = REQ_NONE;
      bg_pending = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [CL_W-1:0] cluster_of(logic [CPU_W-1:0] cpu);
      if (cpu <= last_cpu[CL_LITTLE]) return CL_LITTLE;
      if (cpu <= last_cpu[CL_MID]) return CL_MID;
      if (cpu <= last_cpu[CL_BIG]) return CL_BIG;
      return CL_LITTLE;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ALERT_THRESHOLD:  alert = data[PCT_W-1:0];
        REG_LITTLE_LAST_CPU:  last_cpu[CL_LITTLE] = data[CPU_W-1:0];
        REG_MID_LAST_CPU:     last_cpu[CL_MID] = data[CPU_W-1:0];
        REG_BIG_LAST_CPU:     last_cpu[CL_BIG] = data[CPU_W-1:0];
        REG_LITTLE_CAP_LIMIT: cap_limit[CL_LITTLE] = data[CAP_W-1:0];
        REG_MID_CAP_LIMIT:    cap_limit[CL_MID] = data[CAP_W-1:0];
        REG_BIG_CAP_LIMIT:    cap_limit[CL_BIG] = data[CAP_W-1:0];
        default: ;
      endcase
    endfunction

    // Idle rate over the interval since the previous sample of the same CPU, and
    // the flag and request updates that it causes.
    function rate_report_t predict_rate(cpu_sample_t s);
      rate_report_t r;
      logic [CTR_W-1:0] d_idle;
      logic [CTR_W-1:0] d_wall;
      logic [CTR_W+6:0] scaled;
      logic [CTR_W+6:0] ratio;
      logic [CL_W-1:0]  cl;
      r = '0;
      if (s.opcode == OP_CLEAR) begin
        bg_pending = 1'b0;
        return r;
      end
      cl = cluster_of(s.cpu);
      r.cluster = cl;
      if (s.cpu < CPU_COUNT_DEF) begin
        d_idle = s.idle_total - prev_idle[s.cpu];
        d_wall = s.wall_total - prev_wall[s.cpu];
        prev_idle[s.cpu] = s.idle_total;
        prev_wall[s.cpu] = s.wall_total;
        if (d_wall != '0) begin
          r.measured = 1'b1;
          if (d_idle >= d_wall) begin
            r.idle_percent = FULL_PERCENT;
          end else begin
            scaled = {7'd0, d_idle} * 71'd100;
            ratio = scaled / {7'd0, d_wall};
            r.idle_percent = ratio[PCT_W-1:0];
          end
          if (r.idle_percent < alert) begin
            bg_pending = 1'b1;
            request[cl] = REQ_RAISE;
          end else if (s.current_cap > cap_limit[cl]) begin
            bg_pending = 1'b1;
            request[cl] = REQ_LOWER;
          end
        end
      end
      r.cluster_request = request[cl];
      r.background_pending = bg_pending;
      return r;
    endfunction

    function void note_sample(cpu_sample_t s);
      awaited.push_back(predict_rate(s));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    task report(string what);
      if (errors < MAX_REPORTS) $display("MISMATCH at result %0d: %s", checked, what);
      errors++;
    endtask

    task check_result(rate_report_t got);
      rate_report_t want;
      if (awaited.size() == 0) begin
        report("result beat with no sample outstanding");
        return;
      end
      want = awaited.pop_front();
      if (got.idle_percent !== want.idle_percent)
        report($sformatf("idle_percent %0d, expected %0d", got.idle_percent,
                         want.idle_percent));
      if (got.cluster !== want.cluster)
        report($sformatf("cluster %0d, expected %0d", got.cluster, want.cluster));
      if (got.measured !== want.measured)
        report($sformatf("measured %b, expected %b", got.measured, want.measured));
      if (got.cluster_request !== want.cluster_request)
        report($sformatf("cluster_request %0d, expected %0d", got.cluster_request,
                         want.cluster_request));
      if (got.background_pending !== want.background_pending)
        report($sformatf("background_pending %b, expected %b", got.background_pending,
                         want.background_pending));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  cirm_in_if  sample_ch ();
  cirm_out_if result_ch ();
  cirm_cfg_if cfg_ch ();

  cpu_idle_rate_monitor u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rate_scoreboard sb;
  logic [CTR_W-1:0] feed_idle [CPU_COUNT_DEF];
  logic [CTR_W-1:0] feed_wall [CPU_COUNT_DEF];
  int  gap_pct;
  int  stall_pct;
  int  stall_left;
  int  quiet_cycles;
  bit  calm;
  bit  hold_req;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Monitors: configuration and sample beats update the predictor before any
  // result beat of the same edge is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.apply_reg(cfg_ch.index, cfg_ch.data);
      if (sample_ch.valid && sample_ch.ready)
        sb.note_sample(cpu_sample_t'{opcode: sample_ch.opcode, cpu: sample_ch.cpu,
                         idle_total: sample_ch.idle_total, wall_total: sample_ch.wall_total,
                         current_cap: sample_ch.current_cap});
      if (result_ch.valid && result_ch.ready)
        sb.check_result(rate_report_t'{idle_percent: result_ch.idle_percent,
                          cluster: result_ch.cluster,
                          measured: result_ch.measured,
                          cluster_request: result_ch.cluster_request,
                          background_pending: result_ch.background_pending});
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cpu_idle_rate_monitor_tb NOT OK");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  always begin : result_sink
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 10);
    end
    if (stall_left > 0) begin
      result_ch.ready = 1'b0;
      stall_left--;
    end else begin
      result_ch.ready = 1'b1;
    end
  end

  function automatic logic [CTR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Starts and ends at a falling edge; valid stays high after the beat.
  task automatic send_item(cpu_sample_t s);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      sample_ch.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    sample_ch.valid = 1'b1;
    sample_ch.opcode = s.opcode;
    sample_ch.cpu = s.cpu;
    sample_ch.idle_total = s.idle_total;
    sample_ch.wall_total = s.wall_total;
    sample_ch.current_cap = s.current_cap;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_sample(logic [CPU_W-1:0] cpu, logic [CTR_W-1:0] idle,
                             logic [CTR_W-1:0] wall, logic [CAP_W-1:0] cap);
    cpu_sample_t s;
    s = '{opcode: OP_SAMPLE, cpu: cpu, idle_total: idle, wall_total: wall, current_cap: cap};
    feed_idle[cpu] = idle;
    feed_wall[cpu] = wall;
    send_item(s);
  endtask

  // The other fields of a clear carry noise; the block ignores them.
  task automatic send_clear();
    cpu_sample_t s;
    s = '{opcode: OP_CLEAR, cpu: CPU_W'($urandom), idle_total: rand64(),
          wall_total: rand64(), current_cap: CAP_W'($urandom)};
    send_item(s);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [10:0] thr, logic [10:0] little, logic [10:0] mid,
                              logic [10:0] big, logic [10:0] lim_little,
                              logic [10:0] lim_mid, logic [10:0] lim_big);
    cfg_write(REG_ALERT_THRESHOLD, thr);
    cfg_write(REG_LITTLE_LAST_CPU, little);
    cfg_write(REG_MID_LAST_CPU, mid);
    cfg_write(REG_BIG_LAST_CPU, big);
    cfg_write(REG_LITTLE_CAP_LIMIT, lim_little);
    cfg_write(REG_MID_CAP_LIMIT, lim_mid);
    cfg_write(REG_BIG_CAP_LIMIT, lim_big);
    cfg_ch.valid = 1'b0;
  endtask

  // Wait until every expected result is in and the block has gone quiet.
  task automatic settle();
    sample_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CAP_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CAP_LIMIT_RST;
      2:       return '1;
      default: return CAP_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic program_random();
    logic [PCT_W-1:0] thr;
    logic [CPU_W-1:0] b0, b1, b2, t;
    logic [7:0]       junk;
    case ($urandom_range(0, 5))
      0:       thr = '0;
      1:       thr = FULL_PERCENT;
      2:       thr = '1;
      default: thr = PCT_W'($urandom_range(0, 100));
    endcase
    b0 = CPU_W'($urandom);
    b1 = CPU_W'($urandom);
    b2 = CPU_W'($urandom);
    // Mostly ordered bounds; otherwise leave them as drawn.
    if ($urandom_range(0, 3) != 0) begin
      if (b0 > b1) begin t = b0; b0 = b1; b1 = t; end
      if (b1 > b2) begin t = b1; b1 = b2; b2 = t; end
      if (b0 > b1) begin t = b0; b0 = b1; b1 = t; end
    end
    junk = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
    if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    program_regs({junk[3:0], thr}, {junk, b0}, {junk, b1}, {junk, b2}, pick_limit(),
                 pick_limit(), pick_limit());
  endtask

  // Mostly coherent counter sequences with a spread of rates; the rest is
  // clears, zero intervals, saturating intervals and raw noise.
  task automatic send_random();
    int               mode;
    int               pct;
    logic [CPU_W-1:0] cpu;
    logic [CTR_W-1:0] di, dw, unit;
    logic [CAP_W-1:0] cap;
    mode = $urandom_range(0, 99);
    cpu = CPU_W'($urandom);
    case ($urandom_range(0, 3))
      0:       cap = CAP_W'($urandom);
      1:       cap = CAP_W'($urandom_range(0, 1024));
      default: cap = sb.cap_limit[sb.cluster_of(cpu)] + CAP_W'($urandom_range(0, 2)) - 11'd1;
    endcase
    if (mode < 8) begin
      send_clear();
      return;
    end
    if (mode < 16) begin
      send_sample(cpu, rand64(), rand64(), cap);
      return;
    end
    dw = rand64() >> $urandom_range(0, 63);
    if (dw == '0) dw = 64'd1;
    unit = dw / 100;
    pct = $urandom_range(0, 100);
    if (mode < 21) begin
      dw = '0;
      di = rand64() >> $urandom_range(0, 63);
    end else if (mode < 27) begin
      di = dw + (rand64() >> $urandom_range(1, 63));
    end else if (unit == '0) begin
      di = (dw * pct) / 100;
    end else begin
      di = unit * pct + rand64() % (unit + 1);
    end
    send_sample(cpu, feed_idle[cpu] + di, feed_wall[cpu] + dw, cap);
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 30;
    endcase
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.opcode = OP_SAMPLE;
    sample_ch.cpu = '0;
    sample_ch.idle_total = '0;
    sample_ch.wall_total = '0;
    sample_ch.current_cap = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ALERT_THRESHOLD;
    cfg_ch.data = '0;
    foreach (feed_idle[i]) begin
      feed_idle[i] = '0;
      feed_wall[i] = '0;
    end
    gap_pct = 10;
    stall_pct = 10;
    stall_left = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset settings: threshold 12, bounds 3/6/7,
    // limits 1024.
    send_clear();
    send_sample(3'd0, '0, '0, '0);                      // nothing elapsed since reset
    send_sample(3'd0, 64'd5, 64'd100, 11'd0);           // 5 %, raise little
    send_clear();
    send_sample(3'd4, 64'd50, 64'd100, 11'd1025);       // cap above limit, lower mid
    send_sample(3'd7, 64'd200, 64'd100, 11'd2047);      // idle beyond wall, saturates
    send_sample(3'd1, '1, '1, 11'd0);                   // full-scale deltas
    send_sample(3'd1, 64'd5, 64'd10, 11'd1024);         // both counters wrap
    send_sample(3'd2, 64'hFFFF_FFFF_FFFF_FFFE, '1, 11'd1024); // needs the wide product
    send_sample(3'd2, 64'd0, '1, 11'd1);                // wall unchanged: unmeasured
    send_sample(3'd3, 64'd0, 64'd1, 11'd1024);          // zero percent
    send_sample(3'd5, 64'd12, 64'd100, 11'd1024);       // on the threshold, on the limit
    send_sample(3'd6, 64'd11, 64'd100, 11'd2047);       // raise wins over lower
    send_clear();
    settle();

    // Threshold above the range, bounds that leave CPUs 5 to 7 above every bound, zero limits.
    program_regs(11'd127, 11'd1, 11'd2, 11'd4, 11'd0, 11'd0, 11'd0);
    send_sample(3'd5, feed_idle[5] + 64'd100, feed_wall[5] + 64'd100, 11'd0); // above every bound
    send_sample(3'd7, feed_idle[7] + 64'd3, feed_wall[7] + 64'd9, 11'd5);
    send_sample(3'd4, feed_idle[4] + 64'd99, feed_wall[4] + 64'd100, 11'd1);
    settle();
    program_regs(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd2047, 11'd1024);
    send_sample(3'd6, feed_idle[6], feed_wall[6] + 64'd7, 11'd1);  // zero threshold, lower
    send_sample(3'd0, feed_idle[0] + 64'd1, feed_wall[0] + 64'd7, 11'd0);
    send_clear();
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      program_random();
      calm = (ph == PHASES - 1);
      gap_pct = pick_idle_pct();
      stall_pct = pick_idle_pct();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 30) begin
          hold_req = 1'b1;
          gap_pct = 0;
        end
        send_random();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("cpu_idle_rate_monitor_tb OK");
    end else begin
      $display("cpu_idle_rate_monitor_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cirm_pkg.sv
rtl/core/cirm_if.sv
rtl/core/cpu_idle_rate_monitor.sv
tb/cpu_idle_rate_monitor_tb.sv
